>>> sv/ilam_pkg.sv
package ilam_pkg;

	// Fixed register geometry: four controller slots, two registers each
	localparam int unsigned CTRL_SLOTS = 4;
	localparam int unsigned GSI_W      = 10;
	localparam int unsigned COUNT_W    = 6;
	localparam int unsigned SLOT_W     = 2;
	localparam int unsigned ADDR_W     = 5;
	localparam int unsigned DATA_W     = 32;

	// Register select inside one controller slot (paddr bit 2)
	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// Request codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result codes
	typedef enum logic [1:0] {
		ST_GRANTED   = 2'd0,
		ST_TAKEN     = 2'd1,
		ST_FREED     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

endpackage

>>> sv/interrupt_line_allocation_map.sv
// Interrupt line allocation map. Holds one allocation bitmap per interrupt
// controller; controller c covers global interrupt numbers base_gsi_c up to
// base_gsi_c + min(line_count_c, LINES_PER_CONTROLLER) - 1, and a count of
// zero marks it absent. An allocate beat (operation 0) goes to the
// lowest-numbered controller whose window holds the number: status granted
// when the line was free (the line is then marked used), taken otherwise.
// A free beat (operation 1) clears the line in every matching controller and
// reports freed. A number no window covers reports not_found and changes
// nothing. Each request gives exactly one status beat. Requests are taken
// one per clock while in_stall is low: a beat enters an input register,
// and the window compares plus the bitmap read-modify-write finish into
// the output register once it frees or empties; an input beat can still be
// taken while a result waits on out_stall. Bitmaps clear on reset. Registers
// sit at byte address 4*i in the order base_gsi_0, line_count_0, ...,
// line_count_3; write them only while no request is in flight.
module interrupt_line_allocation_map #(
	parameter int unsigned NUM_CONTROLLERS      = 4,
	parameter int unsigned LINES_PER_CONTROLLER = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ilam_pkg::ADDR_W-1:0]     paddr,
	input  logic [ilam_pkg::DATA_W-1:0]     pwdata,
	output logic [ilam_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [ilam_pkg::GSI_W-1:0]      interrupt_number,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status
);

	localparam int unsigned OFF_W  = (LINES_PER_CONTROLLER > 1) ?
		$clog2(LINES_PER_CONTROLLER) : 1;
	localparam int unsigned LINE_W = ilam_pkg::COUNT_W + 1;
	localparam int unsigned END_W  = ilam_pkg::GSI_W + 1;
	localparam logic [LINE_W-1:0] MAX_LINES = LINE_W'(LINES_PER_CONTROLLER);

	// Configuration registers
	logic [ilam_pkg::GSI_W-1:0]   base_q  [ilam_pkg::CTRL_SLOTS];
	logic [ilam_pkg::COUNT_W-1:0] count_q [ilam_pkg::CTRL_SLOTS];

	// Allocation bitmaps
	logic [LINES_PER_CONTROLLER-1:0] map_q [NUM_CONTROLLERS];
	logic [LINES_PER_CONTROLLER-1:0] map_d [NUM_CONTROLLERS];

	// Input stage
	logic                       valid_s1;
	logic                       op_s1;
	logic [ilam_pkg::GSI_W-1:0] num_s1;

	// Output stage
	logic                       out_valid_q;
	ilam_pkg::status_t          status_q;

	logic                       advance;
	logic                       fire;
	logic [NUM_CONTROLLERS-1:0] hit;
	logic [NUM_CONTROLLERS-1:0] sel;
	logic [OFF_W-1:0]           off [NUM_CONTROLLERS];
	ilam_pkg::status_t          status_d;

	logic                          cfg_wr;
	logic [ilam_pkg::SLOT_W-1:0]   cfg_slot;
	logic                          cfg_reg;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign cfg_slot = paddr[4:3];
	assign cfg_reg  = paddr[2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < ilam_pkg::CTRL_SLOTS; c++) begin
				base_q[c]  <= '0;
				count_q[c] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_reg)
				ilam_pkg::REG_BASE:  base_q[cfg_slot]  <= pwdata[ilam_pkg::GSI_W-1:0];
				ilam_pkg::REG_COUNT: count_q[cfg_slot] <= pwdata[ilam_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		prdata = '0;
		unique case (cfg_reg)
			ilam_pkg::REG_BASE:  prdata[ilam_pkg::GSI_W-1:0]   = base_q[cfg_slot];
			ilam_pkg::REG_COUNT: prdata[ilam_pkg::COUNT_W-1:0] = count_q[cfg_slot];
			default: ;
		endcase
	end

	// Handshake: stage 1 moves on when the output register is free or emptying
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= operation;
			num_s1 <= interrupt_number;
		end
	end

	// Window compares, one per controller
	always_comb begin
		logic [LINE_W-1:0]          lines;
		logic [END_W-1:0]           win_end;
		logic [ilam_pkg::GSI_W-1:0] diff;
		for (int c = 0; c < NUM_CONTROLLERS; c++) begin
			lines   = (LINE_W'(count_q[c]) > MAX_LINES) ? MAX_LINES : LINE_W'(count_q[c]);
			win_end = END_W'(base_q[c]) + END_W'(lines);
			diff    = num_s1 - base_q[c];
			hit[c]  = (num_s1 >= base_q[c]) && (END_W'(num_s1) < win_end);
			off[c]  = diff[OFF_W-1:0];
		end
	end

	// Lowest matching controller serves an allocate
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int c = 0; c < NUM_CONTROLLERS; c++) begin
			sel[c] = hit[c] && !seen;
			seen   = seen || hit[c];
		end
	end

	// Bitmap read-modify-write and status
	always_comb begin
		status_d = ilam_pkg::ST_NOT_FOUND;
		for (int c = 0; c < NUM_CONTROLLERS; c++) begin
			map_d[c] = map_q[c];
			if (op_s1 == ilam_pkg::OP_ALLOC) begin
				if (sel[c]) begin
					if (map_q[c][off[c]]) begin
						status_d = ilam_pkg::ST_TAKEN;
					end else begin
						status_d = ilam_pkg::ST_GRANTED;
						map_d[c][off[c]] = 1'b1;
					end
				end
			end else if (hit[c]) begin
				status_d = ilam_pkg::ST_FREED;
				map_d[c][off[c]] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CONTROLLERS; c++) begin
				map_q[c] <= '0;
			end
		end else if (fire) begin
			for (int c = 0; c < NUM_CONTROLLERS; c++) begin
				map_q[c] <= map_d[c];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	// At most one controller serves an allocate
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel))
		else $error("more than one controller selected");

	// A request held in stage 1 always has a result waiting ahead of it
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// A request that leaves stage 1 shows up as a result next cycle
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("request lost between stages");

	// A number outside every window reports not_found
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (hit == '0)) |=> (status_q == ilam_pkg::ST_NOT_FOUND))
		else $error("uncovered number did not report not_found");

	// A free request never reports an allocate outcome
	a_free_status: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (op_s1 == ilam_pkg::OP_FREE)) |=>
		(status_q == ilam_pkg::ST_FREED || status_q == ilam_pkg::ST_NOT_FOUND))
		else $error("free request gave allocate status");
`endif

endmodule

>>> test/interrupt_line_allocation_map_tb.sv
// Predicts the status of every request from its own copy of the windows and
// bitmaps, and keeps the statuses still owed by the block in arrival order.
class allocation_scoreboard #(int unsigned NUM_CTRL = 4, int unsigned LINES = 32);
	logic [ilam_pkg::GSI_W-1:0]   base_gsi   [ilam_pkg::CTRL_SLOTS];
	logic [ilam_pkg::COUNT_W-1:0] line_count [ilam_pkg::CTRL_SLOTS];
	logic [31:0]                  line_map   [ilam_pkg::CTRL_SLOTS];
	ilam_pkg::status_t            owed       [$];
	int                           tally      [4];

	function void reset_state();
		for (int c = 0; c < ilam_pkg::CTRL_SLOTS; c++) begin
			base_gsi[c] = '0;
			line_count[c] = '0;
			line_map[c] = '0;
		end
		for (int s = 0; s < 4; s++)
			tally[s] = 0;
		owed.delete();
	endfunction

	function void set_register(int slot, logic sel, logic [ilam_pkg::DATA_W-1:0] value);
		if (sel == ilam_pkg::REG_BASE)
			base_gsi[slot] = value[ilam_pkg::GSI_W-1:0];
		else
			line_count[slot] = value[ilam_pkg::COUNT_W-1:0];
	endfunction

	// Usable lines of a controller: counts saturate, missing slots are absent
	function int window_lines(int c);
		if (c >= NUM_CTRL)
			return 0;
		return (line_count[c] > LINES) ? LINES : line_count[c];
	endfunction

	function bit in_window(int c, logic [ilam_pkg::GSI_W-1:0] num, output int offset);
		int lines;
		lines = window_lines(c);
		if (lines == 0 || num < base_gsi[c] || int'(num) >= int'(base_gsi[c]) + lines)
			return 1'b0;
		offset = int'(num) - int'(base_gsi[c]);
		return 1'b1;
	endfunction

	// Note an accepted request and update the bitmaps
	function void note_request(logic op, logic [ilam_pkg::GSI_W-1:0] num);
		ilam_pkg::status_t result;
		int offset;
		result = ilam_pkg::ST_NOT_FOUND;
		if (op == ilam_pkg::OP_ALLOC) begin
			// first matching controller only
			for (int c = 0; c < ilam_pkg::CTRL_SLOTS; c++) begin
				if (result == ilam_pkg::ST_NOT_FOUND && in_window(c, num, offset)) begin
					if (line_map[c][offset]) begin
						result = ilam_pkg::ST_TAKEN;
					end else begin
						line_map[c][offset] = 1'b1;
						result = ilam_pkg::ST_GRANTED;
					end
				end
			end
		end else begin
			// every matching controller
			for (int c = 0; c < ilam_pkg::CTRL_SLOTS; c++) begin
				if (in_window(c, num, offset)) begin
					line_map[c][offset] = 1'b0;
					result = ilam_pkg::ST_FREED;
				end
			end
		end
		owed.push_back(result);
		tally[result]++;
	endfunction

	// Compare one status beat with the oldest owed status
	function bit check_status(logic [1:0] got, output string why);
		ilam_pkg::status_t want;
		if (owed.size() == 0) begin
			why = $sformatf("status %0d arrived with no request outstanding", got);
			return 1'b0;
		end
		want = owed.pop_front();
		if (got !== want) begin
			why = $sformatf("status %0d, expected %0d (%s)", got, want, want.name());
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function int pending();
		return owed.size();
	endfunction
endclass

module interrupt_line_allocation_map_tb;

	localparam int NUM_CTRL       = 4;
	localparam int LINES          = 32;
	localparam int RANDOM_PHASES  = 13;
	localparam int PHASE_REQUESTS = 100;
	localparam int FLOOD_REQUESTS = 40;
	localparam int HOLD_CYCLES    = 60;
	localparam int QUIET_LIMIT    = 1000;
	localparam int SHOWN_MAX      = 50;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ilam_pkg::ADDR_W-1:0]   paddr;
	logic [ilam_pkg::DATA_W-1:0]   pwdata;
	logic [ilam_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_stall;
	logic                          operation;
	logic [ilam_pkg::GSI_W-1:0]    interrupt_number;
	logic                          out_valid;
	logic                          out_stall;
	logic [1:0]                    status;

	allocation_scoreboard #(NUM_CTRL, LINES) sb;
	int    errors = 0;
	int    settings;
	int    quiet_cycles = 0;
	bit    steady;
	int    hold_asks;
	string mismatch_note;

	interrupt_line_allocation_map #(
		.NUM_CONTROLLERS      (NUM_CTRL),
		.LINES_PER_CONTROLLER (LINES)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.interrupt_number (interrupt_number),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= SHOWN_MAX)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// One APB write; leaves psel high so writes can run back to back
	task automatic write_register(input int slot, input logic sel,
			input logic [ilam_pkg::DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {slot[ilam_pkg::SLOT_W-1:0], sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_register(slot, sel, value);
	endtask

	// Rewrite the base and count of every controller
	task automatic program_windows(
			input logic [ilam_pkg::GSI_W-1:0]   bases  [ilam_pkg::CTRL_SLOTS],
			input logic [ilam_pkg::COUNT_W-1:0] counts [ilam_pkg::CTRL_SLOTS]);
		for (int c = 0; c < ilam_pkg::CTRL_SLOTS; c++) begin
			write_register(c, ilam_pkg::REG_BASE, ilam_pkg::DATA_W'(bases[c]));
			write_register(c, ilam_pkg::REG_COUNT, ilam_pkg::DATA_W'(counts[c]));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings++;
	endtask

	// Offer one request beat after a random gap and hold it until taken
	task automatic send_request(input logic op, input logic [ilam_pkg::GSI_W-1:0] num);
		int gap;
		gap = steady ? 0 : int'($urandom_range(0, 10));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		interrupt_number <= num;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(op, num);
	endtask

	// Stop sending and wait until every owed status has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly numbers in or just past a live window, some anywhere
	function automatic logic [ilam_pkg::GSI_W-1:0] pick_number();
		int c;
		int lines;
		c = int'($urandom_range(0, ilam_pkg::CTRL_SLOTS - 1));
		lines = sb.window_lines(c);
		if (lines > 0 && $urandom_range(0, 9) < 8)
			return ilam_pkg::GSI_W'(sb.base_gsi[c] + $urandom_range(0, lines));
		return ilam_pkg::GSI_W'($urandom);
	endfunction

	// Result sink: random stall before each beat, one long hold-off on request
	initial begin : result_sink
		int hold;
		int holds_done;
		holds_done = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = steady ? 0 : int'($urandom_range(0, 10));
			if (hold_asks != holds_done) begin
				holds_done++;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Check every status beat
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall && !sb.check_status(status, mismatch_note))
			report_mismatch(mismatch_note);
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
			$display("[interrupt_line_allocation_map] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int phase;
		int k;
		int total;
		logic [ilam_pkg::GSI_W-1:0]   bases  [ilam_pkg::CTRL_SLOTS];
		logic [ilam_pkg::COUNT_W-1:0] counts [ilam_pkg::CTRL_SLOTS];

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		operation = ilam_pkg::OP_ALLOC;
		interrupt_number = '0;
		settings = 0;
		steady = 1'b0;
		hold_asks = 0;
		sb = new;
		sb.reset_state();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every controller absent out of reset
		send_request(ilam_pkg::OP_ALLOC, 10'd0);
		send_request(ilam_pkg::OP_FREE, 10'd1023);
		drain_results();

		// c0 0..31, c1 at the top with a saturating count, c2 inside c0, c3 one line
		bases = '{10'd0, 10'd1000, 10'd16, 10'd500};
		counts = '{6'd32, 6'd63, 6'd8, 6'd1};
		program_windows(bases, counts);
		send_request(ilam_pkg::OP_ALLOC, 10'd0);
		send_request(ilam_pkg::OP_ALLOC, 10'd0);
		send_request(ilam_pkg::OP_ALLOC, 10'd31);
		send_request(ilam_pkg::OP_ALLOC, 10'd32);
		// overlap: allocate lands in c0 only, free clears both
		send_request(ilam_pkg::OP_ALLOC, 10'd16);
		send_request(ilam_pkg::OP_ALLOC, 10'd16);
		send_request(ilam_pkg::OP_FREE, 10'd16);
		send_request(ilam_pkg::OP_ALLOC, 10'd16);
		send_request(ilam_pkg::OP_ALLOC, 10'd500);
		send_request(ilam_pkg::OP_ALLOC, 10'd501);
		send_request(ilam_pkg::OP_ALLOC, 10'd499);
		send_request(ilam_pkg::OP_ALLOC, 10'd1023);
		send_request(ilam_pkg::OP_ALLOC, 10'd1000);
		// freeing an already clear line still reports freed
		send_request(ilam_pkg::OP_FREE, 10'd1023);
		send_request(ilam_pkg::OP_FREE, 10'd1023);
		send_request(ilam_pkg::OP_ALLOC, 10'd1023);
		send_request(ilam_pkg::OP_FREE, 10'd999);
		send_request(ilam_pkg::OP_FREE, 10'd700);
		send_request(ilam_pkg::OP_FREE, 10'd0);
		send_request(ilam_pkg::OP_ALLOC, 10'd0);

		// random phases, each under a fresh set of windows
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			case (phase)
				0: begin
					// widest windows, full overlap at the bottom, one at the top edge
					bases = '{10'd0, 10'd0, 10'd992, 10'd1023};
					counts = '{6'd63, 6'd33, 6'd32, 6'd63};
					program_windows(bases, counts);
				end
				1: begin
					bases = '{10'd1023, 10'd1023, 10'd1023, 10'd1023};
					counts = '{6'd0, 6'd0, 6'd0, 6'd0};
					program_windows(bases, counts);
				end
				default: begin
					for (k = 0; k < ilam_pkg::CTRL_SLOTS; k++) begin
						case ($urandom_range(0, 4))
							0: bases[k] = '0;
							1: bases[k] = '1;
							2: bases[k] = ilam_pkg::GSI_W'(
								bases[$urandom_range(0, ilam_pkg::CTRL_SLOTS - 1)]
								+ $urandom_range(0, 8));
							default: bases[k] = ilam_pkg::GSI_W'($urandom);
						endcase
						case ($urandom_range(0, 5))
							0: counts[k] = '0;
							1: counts[k] = 6'd1;
							2: counts[k] = 6'd32;
							3: counts[k] = ilam_pkg::COUNT_W'($urandom_range(33, 63));
							default: counts[k] = ilam_pkg::COUNT_W'($urandom_range(1, 8));
						endcase
					end
					program_windows(bases, counts);
				end
			endcase
			steady = (phase % 4 == 2);
			for (k = 0; k < PHASE_REQUESTS; k++) begin
				// sender pause until the block is empty
				if (k == PHASE_REQUESTS / 2 && phase % 3 == 0)
					drain_results();
				send_request(($urandom_range(0, 9) < 6) ? ilam_pkg::OP_ALLOC : ilam_pkg::OP_FREE,
					pick_number());
			end
		end

		// long result hold-off while requests keep coming back to back
		drain_results();
		steady = 1'b1;
		hold_asks++;
		for (k = 0; k < FLOOD_REQUESTS; k++)
			send_request(($urandom_range(0, 1) == 0) ? ilam_pkg::OP_ALLOC : ilam_pkg::OP_FREE,
				pick_number());
		steady = 1'b0;

		// wind down
		in_valid <= 1'b0;
		for (k = 0; k < 200 && sb.pending() != 0; k++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.pending() != 0)
			report_mismatch($sformatf("%0d status beats never arrived", sb.pending()));

		total = sb.tally[ilam_pkg::ST_GRANTED] + sb.tally[ilam_pkg::ST_TAKEN]
			+ sb.tally[ilam_pkg::ST_FREED] + sb.tally[ilam_pkg::ST_NOT_FOUND];
		$display("Ran %0d requests under %0d window settings, with overlaps, saturated counts",
			total, settings);
		$display("and a full-stall flood: %0d granted, %0d taken, %0d freed, %0d uncovered",
			sb.tally[ilam_pkg::ST_GRANTED], sb.tally[ilam_pkg::ST_TAKEN],
			sb.tally[ilam_pkg::ST_FREED], sb.tally[ilam_pkg::ST_NOT_FOUND]);
		if (errors == 0)
			$display("[interrupt_line_allocation_map] OK");
		else
			$display("[interrupt_line_allocation_map] ERROR");
		$finish;
	end
endmodule

>>> sim.f
sv/ilam_pkg.sv
sv/interrupt_line_allocation_map.sv
test/interrupt_line_allocation_map_tb.sv
